// File: rtl/householder_poll_directions_unit_assert.svh
// Assertion macros for the poll direction unit
`ifndef HOUSEHOLDER_POLL_DIRECTIONS_UNIT_ASSERT_SVH
`define HOUSEHOLDER_POLL_DIRECTIONS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define HPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/hpd_pkg.sv
package hpd_pkg;

    localparam int N_OPT_DEF = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_OFFSET = 2'd1;

    localparam logic [15:0] SAT_LIMIT_RST  = 16'd16384;
    localparam logic [5:0]  EXP_OFFSET_RST = 6'd0;

    localparam logic signed [17:0] HOUSE_ONE = 18'sd16384;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_HOUSE,
        S_SCALE,
        S_EMIT
    } t_state;

endpackage

// File: rtl/householder_poll_directions_unit.sv
// Householder poll direction unit. Send N_OPT load items with start while busy is low; the
// last load of a set starts emission of the N_OPT x 2*N_OPT direction matrix, row by row,
// columns 0 to 2*N_OPT-1, the upper half holding the negated directions. busy is high from
// that last load until the final entry goes out. Each entry passes in order through the
// steps of one shared sequencer (store read, one 16x16 multiply, Householder round and
// clamp, row shift and round, saturate), and no load is taken until the matrix is out.
// Each entry appears on the result ports for exactly one cycle, marked by o_strobe, and
// the receiver cannot stall it: o_last_result flags the final entry. Configuration
// writes are always accepted and belong to idle periods; exponent_offset applies to
// rows loaded after the write.
`include "householder_poll_directions_unit_assert.svh"

module householder_poll_directions_unit
    import hpd_pkg::*;
#(
    parameter int N_OPT = N_OPT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [15:0]        i_random_value,
    input  logic signed [5:0]         i_frame_exponent,
    input  logic signed [5:0]         i_mesh_exponent,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output logic                      o_strobe,
    output logic [$clog2(N_OPT)-1:0]  o_row_index,
    output logic [$clog2(N_OPT):0]    o_column_index,
    output logic signed [15:0]        o_direction_value,
    output logic                      o_last_result
);

    localparam int W_IDX = $clog2(N_OPT);
    localparam int W_COL = W_IDX + 1;
    localparam logic [W_IDX-1:0] IDX_LAST = W_IDX'(N_OPT - 1);
    localparam logic [W_COL-1:0] COL_HALF = W_COL'(N_OPT);
    localparam logic [W_COL-1:0] COL_LAST = W_COL'(2 * N_OPT - 1);

    t_state r_state, n_state;

    logic [W_IDX-1:0] r_load_cnt;
    logic [W_IDX-1:0] r_row;
    logic [W_COL-1:0] r_col;
    logic [15:0]      r_sat_limit;
    logic [5:0]       r_exp_offset;
    logic             r_strobe;
    logic             r_last;

    logic signed [15:0] vec_mem [N_OPT];
    logic [3:0]         shift_mem [N_OPT];

    logic signed [15:0] r_vi;
    logic signed [15:0] r_vj;
    logic [3:0]         r_shift;
    logic signed [31:0] r_prod;
    logic signed [17:0] r_house;
    logic signed [20:0] r_raw;
    logic [W_IDX-1:0]   r_row_out;
    logic [W_COL-1:0]   r_col_out;
    logic signed [15:0] r_dir_out;

    logic             load_fire;
    logic             cfg_fire;
    logic             rd_en;
    logic             emit;
    logic             done;
    logic [W_IDX-1:0] col_j;
    logic             col_neg;
    logic signed [7:0] exp_sum;
    logic [3:0]       load_shift;

    logic [31:0]        prod_mag;
    logic [32:0]        prod_sum;
    logic [16:0]        prod_rnd;
    logic signed [17:0] term;
    logic signed [17:0] house_raw;
    logic signed [17:0] lim_s;
    logic signed [17:0] house_clamped;

    logic [16:0]        house_mag;
    logic [33:0]        scaled;
    logic [33:0]        scaled_sum;
    logic [19:0]        scaled_rnd;
    logic signed [20:0] raw_next;

    logic signed [21:0] emit_val;
    logic signed [15:0] emit_sat;

    assign load_fire   = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    assign col_neg = (r_col >= COL_HALF);
    assign col_j   = col_neg ? W_IDX'(r_col - COL_HALF) : W_IDX'(r_col);
    assign done    = (r_row == IDX_LAST) && (r_col == COL_LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (load_fire && (r_load_cnt == IDX_LAST)) n_state = S_READ;
            end
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = S_HOUSE;
            S_HOUSE: n_state = S_SCALE;
            S_SCALE: n_state = S_EMIT;
            S_EMIT:  n_state = done ? S_IDLE : S_READ;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy  = 1'b1;
        rd_en = 1'b0;
        emit  = 1'b0;
        unique case (r_state)
            S_IDLE:  busy  = 1'b0;
            S_READ:  rd_en = 1'b1;
            S_EMIT:  emit  = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        exp_sum = 8'(i_frame_exponent) - 8'(i_mesh_exponent) + 8'($signed(r_exp_offset));
        if (exp_sum < 0) begin
            load_shift = 4'd0;
        end else if (exp_sum > 8'sd15) begin
            load_shift = 4'd15;
        end else begin
            load_shift = exp_sum[3:0];
        end
    end

    always_comb begin
        prod_mag = r_prod[31] ? 32'(-r_prod) : 32'(r_prod);
        prod_sum = 33'(prod_mag) + 33'(1 << 14);
        prod_rnd = prod_sum[31:15];
        term     = r_prod[31] ? -$signed({1'b0, prod_rnd}) : $signed({1'b0, prod_rnd});
        house_raw = ((r_row == col_j) ? HOUSE_ONE : 18'sd0) - term;
        lim_s     = $signed({2'b00, r_sat_limit});
        if (house_raw > lim_s) begin
            house_clamped = lim_s;
        end else if (house_raw < -lim_s) begin
            house_clamped = -lim_s;
        end else begin
            house_clamped = house_raw;
        end
    end

    always_comb begin
        house_mag  = r_house[17] ? 17'(-r_house) : 17'(r_house);
        scaled     = 34'(house_mag) << r_shift;
        scaled_sum = scaled + 34'(1 << 13);
        scaled_rnd = scaled_sum[33:14];
        raw_next   = r_house[17] ? -$signed({1'b0, scaled_rnd}) : $signed({1'b0, scaled_rnd});
    end

    always_comb begin
        emit_val = col_neg ? -22'(r_raw) : 22'(r_raw);
        if (emit_val > 22'sd32767) begin
            emit_sat = 16'sh7fff;
        end else if (emit_val < -22'sd32768) begin
            emit_sat = -16'sh8000;
        end else begin
            emit_sat = emit_val[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load_cnt   <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_sat_limit  <= SAT_LIMIT_RST;
            r_exp_offset <= EXP_OFFSET_RST;
            r_strobe     <= 1'b0;
            r_last       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
            r_last   <= emit && done;
            if (cfg_fire) begin
                case (i_cfg_index)
                    REG_SAT_LIMIT:  r_sat_limit  <= i_cfg_data;
                    REG_EXP_OFFSET: r_exp_offset <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (load_fire) begin
                r_load_cnt <= (r_load_cnt == IDX_LAST) ? '0 : r_load_cnt + 1'b1;
            end
            if (emit) begin
                if (r_col == COL_LAST) begin
                    r_col <= '0;
                    r_row <= (r_row == IDX_LAST) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_fire) begin
            vec_mem[r_load_cnt]   <= i_random_value;
            shift_mem[r_load_cnt] <= load_shift;
        end
        if (rd_en) begin
            r_vi    <= vec_mem[r_row];
            r_vj    <= vec_mem[col_j];
            r_shift <= shift_mem[r_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) r_prod <= r_vi * r_vj;
        if (r_state == S_HOUSE) r_house <= house_clamped;
        if (r_state == S_SCALE) r_raw <= raw_next;
        if (emit) begin
            r_row_out <= r_row;
            r_col_out <= r_col;
            r_dir_out <= emit_sat;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_last_result     = r_last;
    assign o_row_index       = r_row_out;
    assign o_column_index    = r_col_out;
    assign o_direction_value = r_dir_out;

    `HPD_ASSERT_NEXT(a_emit_strobes, i_clk, i_rst_n, r_state == S_EMIT, o_strobe)
    `HPD_ASSERT_NEXT(a_partial_load_idle, i_clk, i_rst_n,
        load_fire && (r_load_cnt != IDX_LAST), r_state == S_IDLE && !o_strobe)
    `HPD_ASSERT_SAME(a_last_frees, i_clk, i_rst_n, o_strobe && o_last_result, !busy && r_load_cnt == '0)
    `HPD_ASSERT_SAME(a_last_has_strobe, i_clk, i_rst_n, o_last_result, o_strobe)

endmodule

// File: verif/householder_poll_directions_unit_tb.sv
`timescale 1ns / 100ps

module householder_poll_directions_unit_tb
    import hpd_pkg::*;
();

    localparam int ROWS          = N_OPT_DEF;
    localparam int COLS          = 2 * ROWS;
    localparam int RANDOM_LOADS  = 396;
    localparam int CONFIG_EVERY  = 24;
    localparam int LOAD_SETTLE   = 8;
    localparam int DRAIN_SETTLE  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic [1:0]         row;
        logic [2:0]         col;
        logic signed [15:0] value;
        logic               last;
    } t_direction;

    class t_direction_board;
        logic signed [15:0] elements [ROWS];
        logic [3:0]         row_shift [ROWS];
        int                 loads_taken;
        logic [15:0]        clamp_limit;
        logic signed [5:0]  shift_offset;
        t_direction         awaited [$];
        int                 mismatches;

        function new();
            loads_taken  = 0;
            clamp_limit  = SAT_LIMIT_RST;
            shift_offset = EXP_OFFSET_RST;
            mismatches   = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_SAT_LIMIT:  clamp_limit = data;
                REG_EXP_OFFSET: shift_offset = data[5:0];
                default: ;
            endcase
        endfunction

        // divide by 2^k, round to nearest, ties away from zero
        function longint round_scaled(longint num, int k);
            longint mag;
            mag = (num < 0) ? -num : num;
            mag = (mag + (longint'(1) <<< (k - 1))) >>> k;
            return (num < 0) ? -mag : mag;
        endfunction

        function longint clip16(longint x);
            if (x > 32767) return 32767;
            if (x < -32768) return -32768;
            return x;
        endfunction

        function void note_load(logic signed [15:0] element, logic signed [5:0] frame_exp,
                                logic signed [5:0] mesh_exp);
            int shift;
            shift = int'(frame_exp) - int'(mesh_exp) + int'(shift_offset);
            if (shift < 0) shift = 0;
            if (shift > 15) shift = 15;
            elements[loads_taken]  = element;
            row_shift[loads_taken] = 4'(shift);
            loads_taken++;
            if (loads_taken == ROWS) begin
                loads_taken = 0;
                predict_directions();
            end
        endfunction

        function void predict_directions();
            longint     lim;
            longint     prod;
            longint     house;
            longint     row_raw [ROWS];
            t_direction d;
            int         i;
            int         j;
            lim = longint'(clamp_limit);
            for (i = 0; i < ROWS; i++) begin
                for (j = 0; j < ROWS; j++) begin
                    prod  = longint'(elements[i]) * longint'(elements[j]);
                    house = ((i == j) ? longint'(HOUSE_ONE) : longint'(0))
                            - round_scaled(prod, 15);
                    if (house > lim) house = lim;
                    if (house < -lim) house = -lim;
                    row_raw[j] = round_scaled(house * (longint'(1) <<< row_shift[i]), 14);
                end
                for (j = 0; j < COLS; j++) begin
                    d.row   = 2'(i);
                    d.col   = 3'(j);
                    d.value = 16'(clip16((j < ROWS) ? row_raw[j] : -row_raw[j - ROWS]));
                    d.last  = (i == ROWS - 1) && (j == COLS - 1);
                    awaited.push_back(d);
                end
            end
        endfunction

        function void check_direction(logic [1:0] row, logic [2:0] col,
                                      logic signed [15:0] value, logic last);
            t_direction want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected direction: row %0d col %0d value %0d last %0b",
                             row, col, value, last);
                return;
            end
            want = awaited.pop_front();
            if (row !== want.row || col !== want.col || value !== want.value
                    || last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch row/col/value/last: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                             want.row, want.col, want.value, want.last,
                             row, col, value, last);
            end
        endfunction

        function int failures();
            return mismatches + awaited.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic signed [15:0]     i_random_value;
    logic signed [5:0]      i_frame_exponent;
    logic signed [5:0]      i_mesh_exponent;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   o_strobe;
    logic [1:0]             o_row_index;
    logic [2:0]             o_column_index;
    logic signed [15:0]     o_direction_value;
    logic                   o_last_result;

    int               cycle_count = 0;
    int               loads_sent;
    t_direction_board board;

    householder_poll_directions_unit #(
        .N_OPT(ROWS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_random_value    (i_random_value),
        .i_frame_exponent  (i_frame_exponent),
        .i_mesh_exponent   (i_mesh_exponent),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_row_index       (o_row_index),
        .o_column_index    (o_column_index),
        .o_direction_value (o_direction_value),
        .o_last_result     (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                board.note_load(i_random_value, i_frame_exponent, i_mesh_exponent);
            if (i_cfg_valid && o_cfg_ready)
                board.write_register(i_cfg_index, i_cfg_data);
            if (o_strobe)
                board.check_direction(o_row_index, o_column_index, o_direction_value,
                                      o_last_result);
        end
    end

    // hold start high until the transfer; the caller drops it
    task automatic send_load(input logic signed [15:0] element,
                             input logic signed [5:0] frame_exp,
                             input logic signed [5:0] mesh_exp);
        start            <= 1'b1;
        i_random_value   <= element;
        i_frame_exponent <= frame_exp;
        i_mesh_exponent  <= mesh_exp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_loads(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_directions();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] limit, input logic signed [5:0] offset,
                              input bit spare_writes);
        cfg_transfer(REG_SAT_LIMIT, limit);
        cfg_transfer(REG_EXP_OFFSET, {{(CFG_DATA_W - 6){offset[5]}}, offset});
        if (spare_writes) begin
            cfg_transfer(REG_SPARE_2, 16'($urandom));
            cfg_transfer(REG_SPARE_3, 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_registers(input bit spare_writes);
        logic [15:0] limit;
        int          offset;
        case ($urandom_range(0, 4))
            0:       limit = '0;
            1:       limit = 16'd49152;
            default: limit = 16'($urandom_range(0, 49152));
        endcase
        offset = int'($urandom_range(0, 32)) - 16;
        write_regs(limit, 6'(offset), spare_writes);
    endtask

    task automatic send_random_load();
        logic signed [15:0] element;
        logic signed [5:0]  frame_exp;
        logic signed [5:0]  mesh_exp;
        case ($urandom_range(0, 7))
            0:       element = 16'sh7fff;
            1:       element = 16'sh8000;
            2:       element = '0;
            3:       element = 16'(int'($urandom_range(0, 1023)) - 512);
            default: element = 16'($urandom);
        endcase
        frame_exp = 6'($urandom);
        if ($urandom_range(0, 1))
            mesh_exp = 6'($urandom);
        else
            mesh_exp = 6'(int'(frame_exp) - int'($urandom_range(0, 18)) + 2);
        send_load(element, frame_exp, mesh_exp);
    endtask

    initial begin
        int burst;
        int gap;
        board            = new();
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_random_value   = '0;
        i_frame_exponent = '0;
        i_mesh_exponent  = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, shifts clamp at both ends
        send_load(16'sh7fff, 6'sh1f, 6'sh20);
        send_load(16'sh8000, 6'sh20, 6'sh1f);
        send_load(16'sh0000, 6'sd0, 6'sd0);
        send_load(16'sh0001, 6'sd5, 6'sd3);
        drain_directions();

        // widest clamp, largest offset, negated full-scale entries
        write_regs(16'd49152, 6'sd16, 1'b0);
        send_load(16'sh8000, 6'sd0, 6'sd15);
        send_load(16'sh8000, 6'sd0, 6'sd0);
        send_load(16'sh4000, 6'sh20, 6'sh20);
        send_load(16'shffff, 6'sd0, 6'sh1f);
        drain_directions();

        // zero clamp and smallest offset, then rewrite in the middle of loading
        write_regs(16'd0, -6'sd16, 1'b1);
        send_load(16'sd12345, 6'sh1f, 6'sd0);
        send_load(-16'sd20000, 6'sd0, 6'sd0);
        hold_loads(LOAD_SETTLE);
        write_regs(16'd30000, 6'sd5, 1'b1);
        send_load(16'sh8000, 6'sd3, 6'sd1);
        send_load(16'sh7fff, 6'sh20, 6'sh1f);

        loads_sent = 0;
        while (loads_sent < RANDOM_LOADS) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && loads_sent < RANDOM_LOADS) begin
                send_random_load();
                loads_sent++;
                burst--;
                if (loads_sent % CONFIG_EVERY == 0) begin
                    drain_directions();
                    random_registers($urandom_range(0, 1));
                end else if (loads_sent % CONFIG_EVERY == 10) begin
                    hold_loads(LOAD_SETTLE);
                    random_registers(1'b0);
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                hold_loads(gap);
        end

        drain_directions();
        if (board.failures() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
